[rtl/mmeq_pkg.sv]
// package for the min/max extract queue: sizes, codes and the cell link types
// used by mmeq_cell, mmeq_max_tree and min_max_extract_queue
// no dependencies
package mmeq_pkg;

  localparam int CAPACITY = 256;
  localparam int VAL_W    = 31;
  localparam int TOT_W    = 63;
  localparam int GROUP    = 16;
  localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SHORT = 2'd2
  } status_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_CLOSE  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_TAKE
  } fsm_t;

  typedef struct packed {
    logic             valid;
    logic             gt;
    logic [VAL_W-1:0] val;
  } link_t;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [VAL_W-1:0] val;
  } cell_ctl_t;

endpackage

[rtl/mmeq_cell.sv]
// one cell of the sorted chain: holds one entry, shifts up on insert,
// shifts down on close; depends on mmeq_pkg
module mmeq_cell import mmeq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  link_t            dn,
  input  link_t            up,
  input  logic             up2_valid,
  output link_t            self,
  output logic [VAL_W-1:0] top_val
);

  logic             valid;
  logic             valid_next;
  logic [VAL_W-1:0] data;
  logic [VAL_W-1:0] data_next;
  logic             gt;

  assign gt      = valid && (data > ctl.val);
  assign self    = '{valid: valid, gt: gt, val: data};
  assign top_val = (valid && !up.valid) ? data : '0;

  always_comb begin
    data_next  = data;
    valid_next = valid;
    priority if (ctl.rem) begin
      data_next  = up.val;
      valid_next = up2_valid;
    end else if (ctl.ins) begin
      valid_next = valid || dn.valid;
      if (dn.gt) begin
        data_next = dn.val;
      end else if (gt || !valid) begin
        data_next = ctl.val;
      end
    end else begin
      data_next  = data;
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[rtl/mmeq_max_tree.sv]
// registered or-tree that picks the value of the topmost occupied cell
// depends on mmeq_pkg
module mmeq_max_tree import mmeq_pkg::*; (
  input  logic             clk,
  input  logic [VAL_W-1:0] leaf [CAPACITY],
  output logic [VAL_W-1:0] max_val
);

  logic [VAL_W-1:0] grp [NGROUPS];

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGROUPS; g++) begin
      logic [VAL_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          acc = acc | leaf[g * GROUP + k];
        end
      end
      grp[g] <= acc;
    end
  end

  always_comb begin
    max_val = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      max_val = max_val | grp[g];
    end
  end

endmodule

[rtl/min_max_extract_queue.sv]
// top level of the min/max extract queue: chain of sorted cells, max tree,
// control and output register; depends on mmeq_pkg, mmeq_cell, mmeq_max_tree
//
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata value, tuser req_type
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata min/max/spread/total, tuser status
//
// an insert or a short close loads the output register from idle; a close with two
// or more entries goes via wait and take: the or-tree over all cells is registered once
// a new transaction is taken only once the output register is free
// reset leaves the store empty and the total at zero, no clearing pass
module min_max_extract_queue import mmeq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,  // value[30:0], zero pad
  input  logic [0:0]   s_axis_tuser,  // req_type[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,  // min_value, max_value, spread, running_total, pad
  output logic [1:0]   m_axis_tuser   // status[1:0]
);

  fsm_t             state;
  fsm_t             state_next;
  link_t            lnk     [CAPACITY];
  logic [VAL_W-1:0] top_vals [CAPACITY];
  logic [VAL_W-1:0] max_val;
  cell_ctl_t        ctl;

  logic             accept;
  logic             is_close;
  logic [VAL_W-1:0] in_val;
  logic             full;
  logic             short_close;
  logic             out_load;

  logic [TOT_W-1:0] total_acc;
  logic [TOT_W-1:0] total_next;
  logic [TOT_W:0]   total_sum;
  logic [VAL_W-1:0] min_val;
  logic [VAL_W-1:0] spread_val;

  status_t          res_status;
  logic [VAL_W-1:0] res_min;
  logic [VAL_W-1:0] res_max;
  logic [VAL_W-1:0] res_spread;
  logic [TOT_W-1:0] res_total;
  status_t          status_next;
  logic [VAL_W-1:0] min_next;
  logic [VAL_W-1:0] max_next;
  logic [VAL_W-1:0] spread_next;

  assign in_val      = s_axis_tdata[VAL_W-1:0];
  assign is_close    = (req_t'(s_axis_tuser[0]) == REQ_CLOSE);
  assign full        = lnk[CAPACITY-1].valid;
  assign short_close = !lnk[1].valid;
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign min_val     = lnk[0].val;
  assign spread_val  = max_val - min_val;
  assign total_sum   = {1'b0, total_acc} + {{(TOT_W + 1 - VAL_W){1'b0}}, spread_val};

  assign ctl.ins = accept && !is_close && (in_val != '0) && !full;
  assign ctl.rem = (state == S_TAKE);
  assign ctl.val = in_val;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t dn_l;
    link_t up_l;
    logic  up2_v;
    if (i == 0) begin : g_first
      assign dn_l = '{valid: 1'b1, gt: 1'b0, val: '0};
    end else begin : g_mid_dn
      assign dn_l = lnk[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign up_l = '0;
    end else begin : g_mid_up
      assign up_l = lnk[i+1];
    end
    if (i + 2 < CAPACITY) begin : g_up2
      assign up2_v = lnk[i+2].valid;
    end else begin : g_no_up2
      assign up2_v = 1'b0;
    end
    mmeq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .dn        (dn_l),
      .up        (up_l),
      .up2_valid (up2_v),
      .self      (lnk[i]),
      .top_val   (top_vals[i])
    );
  end

  mmeq_max_tree u_max_tree (
    .clk     (clk),
    .leaf    (top_vals),
    .max_val (max_val)
  );

  assign s_axis_tready = (state == S_IDLE) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && is_close && !short_close) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT:  state_next = S_TAKE;
      S_TAKE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_load    = 1'b0;
    status_next = ST_OK;
    min_next    = '0;
    max_next    = '0;
    spread_next = '0;
    total_next  = total_acc;
    unique case (state)
      S_IDLE: begin
        if (accept && !is_close) begin
          out_load = 1'b1;
          if (in_val != '0 && full) begin
            status_next = ST_FULL;
          end
        end else if (accept && short_close) begin
          out_load    = 1'b1;
          status_next = ST_SHORT;
        end
      end
      S_TAKE: begin
        out_load    = 1'b1;
        min_next    = min_val;
        max_next    = max_val;
        spread_next = spread_val;
        total_next  = total_sum[TOT_W] ? TOT_MAX : total_sum[TOT_W-1:0];
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      total_acc     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state     <= state_next;
      total_acc <= total_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_status <= status_next;
      res_min    <= min_next;
      res_max    <= max_next;
      res_spread <= spread_next;
      res_total  <= total_next;
    end
  end

  assign m_axis_tuser = res_status;
  assign m_axis_tdata = {4'b0, res_total, res_spread, res_max, res_min};

`ifndef SYNTHESIS
  a_fill_contiguous: assert property (@(posedge clk) disable iff (rst)
    lnk[1].valid |-> lnk[0].valid)
    else $error("cell occupancy not contiguous");

  a_sorted_bottom: assert property (@(posedge clk) disable iff (rst)
    lnk[1].valid |-> (lnk[1].val >= lnk[0].val))
    else $error("lowest cells out of order");

  a_take_after_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAKE) |-> ($past(state) == S_WAIT))
    else $error("removal step without tree wait");

  a_close_order: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_status == ST_OK) |-> (res_max >= res_min))
    else $error("reported max below min");

  a_spread: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res_spread == res_max - res_min))
    else $error("spread does not match ends");

  a_no_entry_on_take: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAKE) |-> !s_axis_tready)
    else $error("input open during removal");
`endif

endmodule
